// ===== sv/ukid_pkg.sv =====
// Package: shared types, codes and match patterns for the UART keyword and idle detector.
`timescale 1ns / 1ps

package ukid_pkg;

  typedef enum logic {
    OP_BYTE = 1'b0,
    OP_TICK = 1'b1
  } op_t;

  localparam logic [2:0] LS_UAP     = 3'd0;
  localparam logic [2:0] LS_CLOUD   = 3'd1;
  localparam logic [2:0] LS_LOCAL   = 3'd2;
  localparam logic [2:0] LS_OFFLINE = 3'd3;
  localparam logic [2:0] LS_UNPROV  = 3'd4;

  localparam logic [7:0]  IDLE_LIMIT_RESET = 8'd10;
  localparam logic [15:0] BYTE_COUNT_MAX   = 16'hFFFF;
  localparam logic [8:0]  IDLE_COUNT_MAX   = 9'd511;

  localparam logic [3:0] IDENT_LEN   = 4'd13;
  localparam logic [1:0] UAP_LEN     = 2'd3;
  localparam logic [2:0] CLOUD_LEN   = 3'd5;
  localparam logic [2:0] LOCAL_LEN   = 3'd5;
  localparam logic [2:0] OFFLINE_LEN = 3'd7;
  localparam logic [2:0] UNPROV_LEN  = 3'd6;

  localparam logic [7:0] IDENT_PAT [0:12] = '{
    8'h75, 8'h63, 8'h74, 8'h20, 8'h69, 8'h64, 8'h22,
    8'h3A, 8'h35, 8'h35, 8'h33, 8'h31, 8'h2C
  };
  localparam logic [7:0] UAP_PAT     [0:2] = '{8'h75, 8'h61, 8'h70};
  localparam logic [7:0] CLOUD_PAT   [0:4] = '{8'h63, 8'h6C, 8'h6F, 8'h75, 8'h64};
  localparam logic [7:0] LOCAL_PAT   [0:4] = '{8'h6C, 8'h6F, 8'h63, 8'h61, 8'h6C};
  localparam logic [7:0] OFFLINE_PAT [0:6] = '{
    8'h6F, 8'h66, 8'h66, 8'h6C, 8'h69, 8'h6E, 8'h65
  };
  localparam logic [7:0] UNPROV_PAT  [0:5] = '{
    8'h75, 8'h6E, 8'h70, 8'h72, 8'h6F, 8'h76
  };

  typedef struct packed {
    op_t        operation;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic        state_valid;
    logic [2:0]  link_state;
    logic        ident_match;
    logic        frame_done;
    logic [15:0] frame_length;
  } out_item_t;

  typedef struct packed {
    logic ident_hit;
    logic uap_hit;
    logic cloud_hit;
    logic local_hit;
    logic offline_hit;
    logic unprov_hit;
  } match_hits_t;

endpackage

// ===== sv/ukid_matchers.sv =====
// Six naive sequence matchers over the received byte stream.
`timescale 1ns / 1ps

module ukid_matchers import ukid_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        advance,
  input  logic [7:0]  rx_byte,
  output match_hits_t hits
);

  logic [3:0] ident_progress, ident_progress_next;
  logic [1:0] uap_progress, uap_progress_next;
  logic [2:0] cloud_progress, cloud_progress_next;
  logic [2:0] local_progress, local_progress_next;
  logic [2:0] offline_progress, offline_progress_next;
  logic [2:0] unprov_progress, unprov_progress_next;

  logic ident_eq, uap_eq, cloud_eq, local_eq, offline_eq, unprov_eq;

  always_comb begin
    ident_eq   = (ident_progress < IDENT_LEN) && (rx_byte == IDENT_PAT[ident_progress]);
    uap_eq     = (uap_progress < UAP_LEN) && (rx_byte == UAP_PAT[uap_progress]);
    cloud_eq   = (cloud_progress < CLOUD_LEN) && (rx_byte == CLOUD_PAT[cloud_progress]);
    local_eq   = (local_progress < LOCAL_LEN) && (rx_byte == LOCAL_PAT[local_progress]);
    offline_eq = (offline_progress < OFFLINE_LEN)
                 && (rx_byte == OFFLINE_PAT[offline_progress]);
    unprov_eq  = (unprov_progress < UNPROV_LEN) && (rx_byte == UNPROV_PAT[unprov_progress]);

    hits.ident_hit   = ident_eq && (ident_progress == IDENT_LEN - 4'd1);
    hits.uap_hit     = uap_eq && (uap_progress == UAP_LEN - 2'd1);
    hits.cloud_hit   = cloud_eq && (cloud_progress == CLOUD_LEN - 3'd1);
    hits.local_hit   = local_eq && (local_progress == LOCAL_LEN - 3'd1);
    hits.offline_hit = offline_eq && (offline_progress == OFFLINE_LEN - 3'd1);
    hits.unprov_hit  = unprov_eq && (unprov_progress == UNPROV_LEN - 3'd1);

    ident_progress_next   = (ident_eq && !hits.ident_hit) ? ident_progress + 4'd1 : 4'd0;
    uap_progress_next     = (uap_eq && !hits.uap_hit) ? uap_progress + 2'd1 : 2'd0;
    cloud_progress_next   = (cloud_eq && !hits.cloud_hit) ? cloud_progress + 3'd1 : 3'd0;
    local_progress_next   = (local_eq && !hits.local_hit) ? local_progress + 3'd1 : 3'd0;
    offline_progress_next = (offline_eq && !hits.offline_hit)
                            ? offline_progress + 3'd1 : 3'd0;
    unprov_progress_next  = (unprov_eq && !hits.unprov_hit) ? unprov_progress + 3'd1 : 3'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ident_progress   <= 4'd0;
      uap_progress     <= 2'd0;
      cloud_progress   <= 3'd0;
      local_progress   <= 3'd0;
      offline_progress <= 3'd0;
      unprov_progress  <= 3'd0;
    end else if (advance) begin
      ident_progress   <= ident_progress_next;
      uap_progress     <= uap_progress_next;
      cloud_progress   <= cloud_progress_next;
      local_progress   <= local_progress_next;
      offline_progress <= offline_progress_next;
      unprov_progress  <= unprov_progress_next;
    end
  end

  a_ident_range: assert property (@(posedge clk) disable iff (rst)
    ident_progress < IDENT_LEN)
    else $error("ident matcher progress out of range");

  a_uap_range: assert property (@(posedge clk) disable iff (rst)
    uap_progress < UAP_LEN)
    else $error("uap matcher progress out of range");

  a_offline_range: assert property (@(posedge clk) disable iff (rst)
    offline_progress < OFFLINE_LEN)
    else $error("offline matcher progress out of range");

endmodule

// ===== sv/uart_keyword_and_idle_detector_core.sv =====
// Top level: UART keyword matchers, frame byte counter and idle-time frame end detector.
// The result beat of an accepted input beat is held in the output register from the next cycle.
// Throughput: one beat per cycle while out_ready is high; in_ready is high whenever the output
// register is empty or being drained in the same cycle.
// Reset (synchronous, rst high): clears byte and idle counts, all matcher progress and
// out_valid, and loads idle_limit with 10.
`timescale 1ns / 1ps

module uart_keyword_and_idle_detector_core import ukid_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  in_item_t   in_data,
  output logic       out_valid,
  input  logic       out_ready,
  output out_item_t  out_data,
  input  logic       cfg_we,
  input  logic [7:0] cfg_data
);

  logic [7:0]  idle_limit;
  logic [15:0] byte_count, byte_count_next;
  logic [8:0]  idle_count, idle_count_next;
  logic [8:0]  idle_inc;
  logic        accept;
  logic        is_byte;
  match_hits_t hits;
  out_item_t   result;

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;
  assign is_byte  = (in_data.operation == OP_BYTE);

  ukid_matchers u_matchers (
    .clk     (clk),
    .rst     (rst),
    .advance (accept && is_byte),
    .rx_byte (in_data.rx_byte),
    .hits    (hits)
  );

  always_comb begin
    result          = '0;
    byte_count_next = byte_count;
    idle_count_next = idle_count;
    idle_inc        = (idle_count < IDLE_COUNT_MAX) ? idle_count + 9'd1 : idle_count;
    if (is_byte) begin
      if (byte_count != BYTE_COUNT_MAX) begin
        byte_count_next = byte_count + 16'd1;
      end
      idle_count_next    = 9'd0;
      result.ident_match = hits.ident_hit;
      result.state_valid = hits.uap_hit || hits.cloud_hit || hits.local_hit
                           || hits.offline_hit || hits.unprov_hit;
      if (hits.cloud_hit) begin
        result.link_state = LS_CLOUD;
      end else if (hits.local_hit) begin
        result.link_state = LS_LOCAL;
      end else if (hits.offline_hit) begin
        result.link_state = LS_OFFLINE;
      end else if (hits.unprov_hit) begin
        result.link_state = LS_UNPROV;
      end else begin
        result.link_state = LS_UAP;
      end
    end else if (byte_count != 16'd0) begin
      idle_count_next = idle_inc;
      if (idle_inc > {1'b0, idle_limit}) begin
        result.frame_done   = 1'b1;
        result.frame_length = byte_count;
        idle_count_next     = 9'd0;
        byte_count_next     = 16'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idle_limit <= IDLE_LIMIT_RESET;
    end else if (cfg_we) begin
      idle_limit <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count <= 16'd0;
      idle_count <= 9'd0;
      out_valid  <= 1'b0;
    end else begin
      if (accept) begin
        byte_count <= byte_count_next;
        idle_count <= idle_count_next;
        out_valid  <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data <= result;
    end
  end

  a_idle_needs_bytes: assert property (@(posedge clk) disable iff (rst)
    byte_count == 16'd0 |-> idle_count == 9'd0)
    else $error("idle count running with no pending bytes");

  a_frame_end_clears: assert property (@(posedge clk) disable iff (rst)
    accept && result.frame_done |=> byte_count == 16'd0 && idle_count == 9'd0)
    else $error("frame end did not clear counts");

  a_frame_nonempty: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.frame_done |-> out_data.frame_length != 16'd0)
    else $error("frame end reported with zero length");

  a_tick_vs_byte: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.frame_done |-> !out_data.state_valid && !out_data.ident_match)
    else $error("frame end and byte match in one beat");

  a_state_idle_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.state_valid |-> out_data.link_state == LS_UAP)
    else $error("link_state set without state_valid");

endmodule
